/* hdl/mi4_pkg.sv */
// Shared types, widths and index helpers for the 4x4 matrix inverse unit.
package mi4_pkg;

    localparam int ELEM_W = 32;
    localparam int CMW    = 96;
    localparam int DMW    = 130;
    localparam int AW     = 131;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_COF     = 12'b0000_0000_0010,
        ST_COF_FIN = 12'b0000_0000_0100,
        ST_COF_WR  = 12'b0000_0000_1000,
        ST_DET     = 12'b0000_0001_0000,
        ST_DET_FIN = 12'b0000_0010_0000,
        ST_DET_WR  = 12'b0000_0100_0000,
        ST_DIV_RD  = 12'b0000_1000_0000,
        ST_DIV_SET = 12'b0001_0000_0000,
        ST_DIV_IT  = 12'b0010_0000_0000,
        ST_DIV_FIN = 12'b0100_0000_0000,
        ST_OUT     = 12'b1000_0000_0000
    } state_t;

    // index n of a 3x3 minor mapped to the 4x4 index, skipping k
    function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] k);
        return (n >= k) ? n + 2'd1 : n;
    endfunction

    // column of minor row n used by Sarrus term t
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] n);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd0, 2'd1, 2'd2};
            3'd4:    p = {2'd1, 2'd2, 2'd0};
            3'd5:    p = {2'd2, 2'd0, 2'd1};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        return 2'(p >> {n, 1'b0});
    endfunction

    function automatic logic perm_neg(input logic [2:0] t);
        return t >= 3'd3;
    endfunction

    function automatic logic [ELEM_W-1:0] mag32(input logic [ELEM_W-1:0] v);
        return v[ELEM_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* hdl/mi4_if.sv */
// Valid/ready channel interfaces for matrix elements and inverse results.
interface mi4_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mi4_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic [31:0] inverse_value;
    logic        singular;
    logic        saturated;
    logic        last_result;

    modport source (output valid, output out_row, output out_col, output inverse_value,
                    output singular, output saturated, output last_result, input ready);
    modport sink   (input valid, input out_row, input out_col, input inverse_value,
                    input singular, input saturated, input last_result, output ready);
endinterface

/* hdl/matrix_inverse_4x4_unit.sv */
// 4x4 fixed-point matrix inverse by adjugate, one shared 32x32 multiplier and restoring divider.
// Elements 1..15: one transaction per cycle. The 16th element starts the computation:
// 16 cofactors, each a sum of Sarrus terms built on the shared multiplier, then the determinant,
// then per result setup, divider iterations, a finish step and output (singular or clamped skip the divider).
// Results leave one at a time; input is not ready from the 16th element until the last result.
// rst_n clears the sequencer and load count; element and cofactor stores are not cleared.
module matrix_inverse_4x4_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mi4_in_if.sink     element,
    mi4_out_if.source  result
);

    localparam int EW   = mi4_pkg::ELEM_W;
    localparam int CMW  = mi4_pkg::CMW;
    localparam int DMW  = mi4_pkg::DMW;
    localparam int AW   = mi4_pkg::AW;
    localparam int CW   = CMW + 1;
    localparam int NW   = CMW + 2 * FRAC_BITS;
    localparam int CMPW = (NW > DMW + EW) ? NW : DMW + EW;

    mi4_pkg::state_t state_reg, state_next;

    logic [3:0]      load_cnt_reg, load_cnt_next;
    logic [3:0]      cof_idx_reg, cof_idx_next;
    logic [2:0]      term_reg, term_next;
    logic [2:0]      step_reg, step_next;
    logic [3:0]      k_reg, k_next;
    logic [4:0]      bit_cnt_reg, bit_cnt_next;
    logic            pacc_reg, pacc_next;

    logic [AW-1:0]   acc_reg, acc_next;
    logic [63:0]     prod_reg, prod_next;
    logic [1:0]      pshift_reg, pshift_next;
    logic            pneg_reg, pneg_next;
    logic [EW-1:0]   a_mag_reg, a_mag_next;
    logic            a_neg_reg, a_neg_next;
    logic            ab_neg_reg, ab_neg_next;
    logic [EW-1:0]   hold_hi_reg, hold_hi_next;
    logic [EW-1:0]   c_mag_reg, c_mag_next;
    logic            tneg_reg, tneg_next;
    logic [DMW-1:0]  det_mag_reg, det_mag_next;
    logic            det_neg_reg, det_neg_next;
    logic            det_zero_reg, det_zero_next;
    logic [DMW-1:0]  rem_reg, rem_next;
    logic [EW-1:0]   qsh_reg, qsh_next;
    logic            qneg_reg, qneg_next;
    logic [EW-1:0]   res_val_reg, res_val_next;
    logic            sing_reg, sing_next;
    logic            sat_reg, sat_next;

    logic [EW-1:0]   elem_mem [16];
    logic [CW-1:0]   cof_mem [16];
    logic [EW-1:0]   elem_rd_reg;
    logic [CW-1:0]   cof_rd_reg;

    logic [3:0]      elem_raddr;
    logic [3:0]      cof_raddr;
    logic [1:0]      sel_n;
    logic [EW-1:0]   mul_a;
    logic [EW-1:0]   mul_b;
    logic            mul_acc;
    logic [1:0]      mul_shift;
    logic            mul_neg;
    logic [EW-1:0]   elem_mag;
    logic            elem_neg;
    logic [CMW-1:0]  cof_mag;
    logic            cof_neg;
    logic            cof_sign;
    logic [AW-1:0]   pp;
    logic [AW-1:0]   acc_sum;
    logic [AW-1:0]   acc_abs;
    logic [NW-1:0]   num;
    logic            div_sat;
    logic [DMW:0]    trial;
    logic            trial_ge;
    logic [DMW:0]    trial_diff;
    logic            in_fire;

    assign in_fire  = element.valid && element.ready;
    assign elem_mag = mi4_pkg::mag32(elem_rd_reg);
    assign elem_neg = elem_rd_reg[EW-1];
    assign cof_mag  = cof_rd_reg[CMW-1:0];
    assign cof_neg  = cof_rd_reg[CW-1];
    assign cof_sign = cof_idx_reg[2] ^ cof_idx_reg[0];

    assign sel_n = (step_reg[1:0] == 2'd3) ? 2'd2 : step_reg[1:0];

    always_comb
    begin
        if (state_reg == mi4_pkg::ST_COF)
        begin
            elem_raddr = {mi4_pkg::skip_idx(sel_n, cof_idx_reg[3:2]),
                          mi4_pkg::skip_idx(mi4_pkg::perm_col(term_reg, sel_n),
                                            cof_idx_reg[1:0])};
        end
        else
        begin
            elem_raddr = {2'b00, k_reg[1:0]};
        end
    end

    assign cof_raddr = (state_reg == mi4_pkg::ST_DET) ? {2'b00, k_reg[1:0]}
                                                      : {k_reg[1:0], k_reg[3:2]};

    assign pp      = AW'(prod_reg) << {pshift_reg, 5'b0};
    assign acc_sum = pacc_reg ? (pneg_reg ? acc_reg - pp : acc_reg + pp) : acc_reg;
    assign acc_abs = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;

    assign num        = NW'(cof_mag) << (2 * FRAC_BITS);
    assign div_sat    = CMPW'(num) >= (CMPW'(det_mag_reg) << EW);
    assign trial      = {rem_reg, qsh_reg[EW-1]};
    assign trial_ge   = trial >= {1'b0, det_mag_reg};
    assign trial_diff = trial - {1'b0, det_mag_reg};

    // memories
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            elem_mem[load_cnt_reg] <= element.element_value;
        end
        if (state_reg == mi4_pkg::ST_COF_WR)
        begin
            cof_mem[cof_idx_reg] <= {acc_reg[AW-1], acc_abs[CMW-1:0]};
        end
        elem_rd_reg <= elem_mem[elem_raddr];
        cof_rd_reg  <= cof_mem[cof_raddr];
    end

    always_comb
    begin
        logic tneg_v;

        tneg_v        = 1'b0;
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        cof_idx_next  = cof_idx_reg;
        term_next     = term_reg;
        step_next     = step_reg;
        k_next        = k_reg;
        bit_cnt_next  = bit_cnt_reg;
        acc_next      = acc_sum;
        a_mag_next    = a_mag_reg;
        a_neg_next    = a_neg_reg;
        ab_neg_next   = ab_neg_reg;
        hold_hi_next  = hold_hi_reg;
        c_mag_next    = c_mag_reg;
        tneg_next     = tneg_reg;
        det_mag_next  = det_mag_reg;
        det_neg_next  = det_neg_reg;
        det_zero_next = det_zero_reg;
        rem_next      = rem_reg;
        qsh_next      = qsh_reg;
        qneg_next     = qneg_reg;
        res_val_next  = res_val_reg;
        sing_next     = sing_reg;
        sat_next      = sat_reg;
        mul_a         = '0;
        mul_b         = '0;
        mul_acc       = 1'b0;
        mul_shift     = 2'd0;
        mul_neg       = 1'b0;

        unique case (state_reg)
            mi4_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15)
                    begin
                        state_next   = mi4_pkg::ST_COF;
                        cof_idx_next = '0;
                        term_next    = '0;
                        step_next    = '0;
                        acc_next     = '0;
                    end
                end
            end
            mi4_pkg::ST_COF:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        step_next = 3'd1;
                    end
                    3'd1:
                    begin
                        a_mag_next = elem_mag;
                        a_neg_next = elem_neg;
                        step_next  = 3'd2;
                    end
                    3'd2:
                    begin
                        mul_a       = a_mag_reg;
                        mul_b       = elem_mag;
                        ab_neg_next = a_neg_reg ^ elem_neg;
                        step_next   = 3'd3;
                    end
                    3'd3:
                    begin
                        tneg_v       = ab_neg_reg ^ elem_neg ^ mi4_pkg::perm_neg(term_reg)
                                       ^ cof_sign;
                        mul_a        = prod_reg[EW-1:0];
                        mul_b        = elem_mag;
                        mul_acc      = 1'b1;
                        mul_neg      = tneg_v;
                        tneg_next    = tneg_v;
                        c_mag_next   = elem_mag;
                        hold_hi_next = prod_reg[2*EW-1:EW];
                        step_next    = 3'd4;
                    end
                    default:
                    begin
                        mul_a     = hold_hi_reg;
                        mul_b     = c_mag_reg;
                        mul_acc   = 1'b1;
                        mul_shift = 2'd1;
                        mul_neg   = tneg_reg;
                        step_next = 3'd0;
                        if (term_reg == 3'd5)
                        begin
                            state_next = mi4_pkg::ST_COF_FIN;
                        end
                        else
                        begin
                            term_next = term_reg + 3'd1;
                        end
                    end
                endcase
            end
            mi4_pkg::ST_COF_FIN:
            begin
                state_next = mi4_pkg::ST_COF_WR;
            end
            mi4_pkg::ST_COF_WR:
            begin
                acc_next  = '0;
                term_next = '0;
                step_next = '0;
                if (cof_idx_reg == 4'd15)
                begin
                    state_next = mi4_pkg::ST_DET;
                    k_next     = '0;
                end
                else
                begin
                    state_next   = mi4_pkg::ST_COF;
                    cof_idx_next = cof_idx_reg + 4'd1;
                end
            end
            mi4_pkg::ST_DET:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        step_next = 3'd1;
                    end
                    3'd1:
                    begin
                        tneg_v     = elem_neg ^ cof_neg;
                        a_mag_next = elem_mag;
                        tneg_next  = tneg_v;
                        mul_a      = elem_mag;
                        mul_b      = cof_mag[EW-1:0];
                        mul_acc    = 1'b1;
                        mul_neg    = tneg_v;
                        step_next  = 3'd2;
                    end
                    3'd2:
                    begin
                        mul_a     = a_mag_reg;
                        mul_b     = cof_mag[2*EW-1:EW];
                        mul_acc   = 1'b1;
                        mul_shift = 2'd1;
                        mul_neg   = tneg_reg;
                        step_next = 3'd3;
                    end
                    default:
                    begin
                        mul_a     = a_mag_reg;
                        mul_b     = cof_mag[3*EW-1:2*EW];
                        mul_acc   = 1'b1;
                        mul_shift = 2'd2;
                        mul_neg   = tneg_reg;
                        step_next = 3'd0;
                        if (k_reg == 4'd3)
                        begin
                            state_next = mi4_pkg::ST_DET_FIN;
                        end
                        else
                        begin
                            k_next = k_reg + 4'd1;
                        end
                    end
                endcase
            end
            mi4_pkg::ST_DET_FIN:
            begin
                state_next = mi4_pkg::ST_DET_WR;
            end
            mi4_pkg::ST_DET_WR:
            begin
                det_neg_next  = acc_reg[AW-1];
                det_mag_next  = DMW'(acc_abs);
                det_zero_next = (acc_reg == '0);
                acc_next      = '0;
                k_next        = '0;
                state_next    = mi4_pkg::ST_DIV_RD;
            end
            mi4_pkg::ST_DIV_RD:
            begin
                state_next = mi4_pkg::ST_DIV_SET;
            end
            mi4_pkg::ST_DIV_SET:
            begin
                qneg_next = cof_neg ^ det_neg_reg;
                if (det_zero_reg)
                begin
                    res_val_next = (k_reg[3:2] == k_reg[1:0]) ? (EW'(1) << FRAC_BITS) : '0;
                    sing_next    = 1'b1;
                    sat_next     = 1'b0;
                    state_next   = mi4_pkg::ST_OUT;
                end
                else if (div_sat)
                begin
                    res_val_next = (cof_neg ^ det_neg_reg) ? {1'b1, {(EW-1){1'b0}}}
                                                           : {1'b0, {(EW-1){1'b1}}};
                    sing_next    = 1'b0;
                    sat_next     = 1'b1;
                    state_next   = mi4_pkg::ST_OUT;
                end
                else
                begin
                    rem_next     = DMW'(num >> EW);
                    qsh_next     = num[EW-1:0];
                    bit_cnt_next = '0;
                    state_next   = mi4_pkg::ST_DIV_IT;
                end
            end
            mi4_pkg::ST_DIV_IT:
            begin
                rem_next     = trial_ge ? trial_diff[DMW-1:0] : trial[DMW-1:0];
                qsh_next     = {qsh_reg[EW-2:0], trial_ge};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31)
                begin
                    state_next = mi4_pkg::ST_DIV_FIN;
                end
            end
            mi4_pkg::ST_DIV_FIN:
            begin
                sing_next  = 1'b0;
                sat_next   = 1'b0;
                state_next = mi4_pkg::ST_OUT;
                if (!qneg_reg)
                begin
                    if (qsh_reg[EW-1])
                    begin
                        res_val_next = {1'b0, {(EW-1){1'b1}}};
                        sat_next     = 1'b1;
                    end
                    else
                    begin
                        res_val_next = qsh_reg;
                    end
                end
                else if (qsh_reg[EW-1] && (qsh_reg[EW-2:0] != '0))
                begin
                    res_val_next = {1'b1, {(EW-1){1'b0}}};
                    sat_next     = 1'b1;
                end
                else
                begin
                    res_val_next = ~qsh_reg + 1'b1;
                end
            end
            mi4_pkg::ST_OUT:
            begin
                if (result.ready)
                begin
                    if (k_reg == 4'd15)
                    begin
                        state_next = mi4_pkg::ST_IDLE;
                        k_next     = '0;
                    end
                    else
                    begin
                        state_next = mi4_pkg::ST_DIV_RD;
                        k_next     = k_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = mi4_pkg::ST_IDLE;
            end
        endcase

        pacc_next   = mul_acc;
        pshift_next = mul_shift;
        pneg_next   = mul_neg;
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mi4_pkg::ST_IDLE;
            load_cnt_reg <= '0;
            cof_idx_reg  <= '0;
            term_reg     <= '0;
            step_reg     <= '0;
            k_reg        <= '0;
            bit_cnt_reg  <= '0;
            pacc_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            cof_idx_reg  <= cof_idx_next;
            term_reg     <= term_next;
            step_reg     <= step_next;
            k_reg        <= k_next;
            bit_cnt_reg  <= bit_cnt_next;
            pacc_reg     <= pacc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        pshift_reg   <= pshift_next;
        pneg_reg     <= pneg_next;
        a_mag_reg    <= a_mag_next;
        a_neg_reg    <= a_neg_next;
        ab_neg_reg   <= ab_neg_next;
        hold_hi_reg  <= hold_hi_next;
        c_mag_reg    <= c_mag_next;
        tneg_reg     <= tneg_next;
        det_mag_reg  <= det_mag_next;
        det_neg_reg  <= det_neg_next;
        det_zero_reg <= det_zero_next;
        rem_reg      <= rem_next;
        qsh_reg      <= qsh_next;
        qneg_reg     <= qneg_next;
        res_val_reg  <= res_val_next;
        sing_reg     <= sing_next;
        sat_reg      <= sat_next;
    end

    assign element.ready        = (state_reg == mi4_pkg::ST_IDLE);
    assign result.valid         = (state_reg == mi4_pkg::ST_OUT);
    assign result.out_row       = k_reg[3:2];
    assign result.out_col       = k_reg[1:0];
    assign result.inverse_value = res_val_reg;
    assign result.singular      = sing_reg;
    assign result.saturated     = sat_reg;
    assign result.last_result   = (k_reg == 4'd15);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(element.ready && result.valid))
        else $error("input accepted while a result is pending");

    a_sing_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.singular |-> !result.saturated)
        else $error("singular result flagged saturated");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last_result |-> result.out_row == 2'd3 && result.out_col == 2'd3)
        else $error("last result not at position 3,3");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.inverse_value == 32'h7FFF_FFFF || result.inverse_value == 32'h8000_0000)
        else $error("saturated result not at a rail");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        element.valid && element.ready && load_cnt_reg == 4'd15 |=> !element.ready)
        else $error("input still ready after sixteenth element");

endmodule
